// ===== design/png_unf_pkg.sv =====
`default_nettype none

package png_unf_pkg;

    // default sizing
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int LINE_BYTES_DEF = 4096;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_HAS_ALPHA    = 2'd2
    } cfg_idx_t;

    // row filter types
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    localparam logic [7:0] FILT_CODE_MAX = 8'd4;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // what the sequencer hands to the reconstruction stage with each byte
    typedef struct packed {
        logic       is_filter;
        filt_t      filt;
        logic [1:0] ch;
        logic       first_row;
        logic       end_row;
        logic       end_img;
        logic       add_alpha;
    } s1_ctrl_t;

    // one rebuilt byte pushed towards the output stage
    typedef struct packed {
        logic       push;
        logic       add_alpha;
        logic [7:0] data;
        logic [1:0] ch;
        logic       end_row;
        logic       end_img;
    } recon_res_t;

    // one output transaction
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [1:0] channel;
        logic       last_of_row;
        logic       last_of_image;
        logic       last_in_run;
    } out_item_t;

endpackage

`default_nettype wire

// ===== design/png_unf_if.sv =====
`default_nettype none

interface png_unf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

interface png_unf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic [1:0] channel;
    logic       last_of_row;
    logic       last_of_image;
    logic       last_in_run;

    modport source (output valid, output pixel_byte, output channel, output last_of_row,
                    output last_of_image, output last_in_run, input ready);
    modport sink   (input valid, input pixel_byte, input channel, input last_of_row,
                    input last_of_image, input last_in_run, output ready);
endinterface

`default_nettype wire

// ===== design/png_unf_line_mem.sv =====
`default_nettype none

module png_unf_line_mem #(
    parameter int DEPTH = png_unf_pkg::LINE_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // new data on a read of the entry being written
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/png_unf_seq.sv =====
`default_nettype none

module png_unf_seq #(
    parameter int MAX_WIDTH  = png_unf_pkg::MAX_WIDTH_DEF,
    parameter int LINE_BYTES = png_unf_pkg::LINE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    raw_byte,
    input  logic [10:0]                   image_width,
    input  logic [15:0]                   image_height,
    input  logic                          has_alpha,
    output logic                          rd_en,
    output logic [$clog2(LINE_BYTES)-1:0] rd_addr,
    output png_unf_pkg::s1_ctrl_t         ctrl
);

    import png_unf_pkg::*;

    localparam int          AW    = $clog2(LINE_BYTES);
    localparam int          CW    = $clog2(LINE_BYTES + 1);
    localparam logic [10:0] W_CAP = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);
    localparam logic [15:0] LB16  = 16'(LINE_BYTES);

    logic          await_filt_reg, await_filt_next;
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    mod3_reg, mod3_next;
    logic [15:0]   row_reg, row_next;
    logic          first_row_reg, first_row_next;
    filt_t         row_filt_reg, row_filt_next;

    logic [10:0] w_eff;
    logic [12:0] stride_raw;
    logic [15:0] stride;
    logic [15:0] h_eff;
    logic [15:0] col_inc;
    logic [16:0] row_inc;
    logic        end_row;
    logic        end_img;
    logic [1:0]  cur_ch;

    // row length in bytes: a zero width counts as one, the width is clamped to MAX_WIDTH, the stride to the line store
    always_comb
    begin
        if (image_width == 11'd0)
        begin
            w_eff = 11'd1;
        end
        else if (image_width > W_CAP)
        begin
            w_eff = W_CAP;
        end
        else
        begin
            w_eff = image_width;
        end
        if (has_alpha)
        begin
            stride_raw = {w_eff, 2'b00};
        end
        else
        begin
            stride_raw = {1'b0, w_eff, 1'b0} + {2'b00, w_eff};
        end
        stride  = ({3'b000, stride_raw} > LB16) ? LB16 : {3'b000, stride_raw};
        h_eff   = (image_height == 16'd0) ? 16'd1 : image_height;
        col_inc = 16'(col_reg) + 16'd1;
        row_inc = {1'b0, row_reg} + 17'd1;
        end_row = (col_inc >= stride);
        end_img = end_row && (row_inc >= {1'b0, h_eff});
        // channel from the byte index, so a format change mid-row applies at once
        cur_ch  = has_alpha ? col_reg[1:0] : mod3_reg;
    end

    always_comb
    begin
        await_filt_next = await_filt_reg;
        col_next        = col_reg;
        mod3_next       = mod3_reg;
        row_next        = row_reg;
        first_row_next  = first_row_reg;
        row_filt_next   = row_filt_reg;
        if (accept)
        begin
            if (await_filt_reg)
            begin
                row_filt_next   = (raw_byte > FILT_CODE_MAX) ? FILT_NONE : filt_t'(raw_byte[2:0]);
                await_filt_next = 1'b0;
                col_next        = '0;
                mod3_next       = 2'd0;
            end
            else if (end_row)
            begin
                await_filt_next = 1'b1;
                if (end_img)
                begin
                    row_next       = 16'd0;
                    first_row_next = 1'b1;
                end
                else
                begin
                    row_next       = row_inc[15:0];
                    first_row_next = 1'b0;
                end
            end
            else
            begin
                col_next  = col_reg + CW'(1);
                mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_filt_reg <= 1'b1;
            col_reg        <= '0;
            mod3_reg       <= 2'd0;
            row_reg        <= 16'd0;
            first_row_reg  <= 1'b1;
            row_filt_reg   <= FILT_NONE;
        end
        else
        begin
            await_filt_reg <= await_filt_next;
            col_reg        <= col_next;
            mod3_reg       <= mod3_next;
            row_reg        <= row_next;
            first_row_reg  <= first_row_next;
            row_filt_reg   <= row_filt_next;
        end
    end

    assign rd_en   = accept && !await_filt_reg;
    assign rd_addr = col_reg[AW-1:0];

    always_comb
    begin
        ctrl.is_filter = await_filt_reg;
        ctrl.filt      = row_filt_reg;
        ctrl.ch        = cur_ch;
        ctrl.first_row = first_row_reg;
        ctrl.end_row   = end_row;
        ctrl.end_img   = end_img;
        ctrl.add_alpha = !has_alpha && (cur_ch == CH_BLUE);
    end

endmodule

`default_nettype wire

// ===== design/png_unf_recon.sv =====
`default_nettype none

module png_unf_recon #(
    parameter int LINE_BYTES = png_unf_pkg::LINE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  png_unf_pkg::s1_ctrl_t         ctrl_in,
    input  logic [7:0]                    raw_in,
    input  logic [$clog2(LINE_BYTES)-1:0] addr_in,
    input  logic [7:0]                    upper_byte,
    input  logic                          out_can_take,
    output logic                          free,
    output logic                          wr_en,
    output logic [$clog2(LINE_BYTES)-1:0] wr_addr,
    output logic [7:0]                    wr_data,
    output png_unf_pkg::recon_res_t       res
);

    import png_unf_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);

    function automatic logic [8:0] abs10(logic signed [9:0] v);
        logic signed [9:0] m;
        m = -v;
        return (v < 0) ? m[8:0] : v[8:0];
    endfunction

    logic           s1_valid_reg;
    s1_ctrl_t       s1_ctrl_reg;
    logic [7:0]     s1_raw_reg;
    logic [AW-1:0]  s1_addr_reg;
    logic [7:0]     left_reg [4];
    logic [7:0]     uleft_reg [4];

    logic              fire;
    logic [7:0]        a, b, c;
    logic [8:0]        sum_ab;
    logic [8:0]        pa, pb, pc;
    logic [7:0]        pred;
    logic [7:0]        x;

    assign fire = s1_valid_reg && (s1_ctrl_reg.is_filter || out_can_take);
    assign free = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_ctrl_reg <= ctrl_in;
            s1_raw_reg  <= raw_in;
            s1_addr_reg <= addr_in;
        end
    end

    // prediction from left, upper and upper-left neighbours
    always_comb
    begin
        a      = left_reg[s1_ctrl_reg.ch];
        c      = uleft_reg[s1_ctrl_reg.ch];
        b      = s1_ctrl_reg.first_row ? 8'd0 : upper_byte;
        sum_ab = {1'b0, a} + {1'b0, b};
        pa     = abs10(signed'({2'b00, b}) - signed'({2'b00, c}));
        pb     = abs10(signed'({2'b00, a}) - signed'({2'b00, c}));
        pc     = abs10(signed'({1'b0, sum_ab}) - signed'({1'b0, c, 1'b0}));
        unique case (s1_ctrl_reg.filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH:
            begin
                if ((pa <= pb) && (pa <= pc))
                begin
                    pred = a;
                end
                else if (pb <= pc)
                begin
                    pred = b;
                end
                else
                begin
                    pred = c;
                end
            end
            default:    pred = 8'd0;
        endcase
        x = s1_raw_reg + pred;
    end

    // neighbour bytes, cleared by each filter byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                left_reg[k]  <= 8'd0;
                uleft_reg[k] <= 8'd0;
            end
        end
        else if (fire)
        begin
            if (s1_ctrl_reg.is_filter)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    left_reg[k]  <= 8'd0;
                    uleft_reg[k] <= 8'd0;
                end
            end
            else
            begin
                left_reg[s1_ctrl_reg.ch]  <= x;
                uleft_reg[s1_ctrl_reg.ch] <= b;
            end
        end
    end

    assign wr_en   = fire && !s1_ctrl_reg.is_filter;
    assign wr_addr = s1_addr_reg;
    assign wr_data = x;

    always_comb
    begin
        res.push      = fire && !s1_ctrl_reg.is_filter;
        res.add_alpha = s1_ctrl_reg.add_alpha;
        res.data      = x;
        res.ch        = s1_ctrl_reg.ch;
        res.end_row   = s1_ctrl_reg.end_row;
        res.end_img   = s1_ctrl_reg.end_img;
    end

endmodule

`default_nettype wire

// ===== design/png_unf_out.sv =====
`default_nettype none

module png_unf_out (
    input  logic                    clk,
    input  logic                    rst_n,
    input  png_unf_pkg::recon_res_t res,
    output logic                    can_take,
    png_unf_out_if.source           out_ch
);

    import png_unf_pkg::*;

    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      pend_reg;
    out_item_t pend_item_reg;
    out_item_t first_item;
    out_item_t alpha_item;
    logic      taken;

    assign taken    = out_valid_reg && out_ch.ready;
    assign can_take = (!out_valid_reg || out_ch.ready) && !pend_reg;

    always_comb
    begin
        first_item.pixel_byte    = res.data;
        first_item.channel       = res.ch;
        first_item.last_of_row   = res.end_row && !res.add_alpha;
        first_item.last_of_image = res.end_img && !res.add_alpha;
        first_item.last_in_run   = !res.add_alpha;
        alpha_item.pixel_byte    = ALPHA_OPAQUE;
        alpha_item.channel       = CH_ALPHA;
        alpha_item.last_of_row   = res.end_row;
        alpha_item.last_of_image = res.end_img;
        alpha_item.last_in_run   = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (res.push)
        begin
            out_valid_reg <= 1'b1;
            pend_reg      <= res.add_alpha;
        end
        else if (taken)
        begin
            out_valid_reg <= pend_reg;
            pend_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            out_item_reg  <= first_item;
            pend_item_reg <= alpha_item;
        end
        else if (taken && pend_reg)
        begin
            out_item_reg <= pend_item_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pixel_byte    = out_item_reg.pixel_byte;
    assign out_ch.channel       = out_item_reg.channel;
    assign out_ch.last_of_row   = out_item_reg.last_of_row;
    assign out_ch.last_of_image = out_item_reg.last_of_image;
    assign out_ch.last_in_run   = out_item_reg.last_in_run;

endmodule

`default_nettype wire

// ===== design/png_scanline_unfilter_rgba_core.sv =====
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth) for
// 8-bit RGB and RGBA rows, one decompressed byte per input transaction.
// The first byte of each row picks its filter (codes above four mean None),
// the rest are rebuilt and leave as RGBA channel bytes, with an opaque alpha
// byte inserted after each blue byte of RGB input. While the output is ready,
// an RGBA stream runs at one byte per cycle in and out, while an RGB stream
// is bounded by the single output port at four output transactions per three
// sample bytes. A rebuilt byte passes the reconstruction register and then the
// output register before it is presented at the output, and either can stall
// on back-pressure from the output port. The previous row sits
// in a line store of LINE_BYTES bytes with one read and one write port: each
// byte reads its upper neighbour on acceptance and writes its own value back
// when it leaves the reconstruction stage. No clearing pass is run after
// reset; the first row of every image uses zeros above it instead.
// Configuration must be written while no transaction is in flight; the block
// itself does not enforce this. A write takes effect at once.

`default_nettype none

module png_scanline_unfilter_rgba_core #(
    parameter int MAX_WIDTH  = png_unf_pkg::MAX_WIDTH_DEF,
    parameter int LINE_BYTES = png_unf_pkg::LINE_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               write_en,
    input  logic [png_unf_pkg::CFG_IDX_W-1:0]  reg_index,
    input  logic [png_unf_pkg::CFG_DATA_W-1:0] write_data,
    png_unf_in_if.sink                         in_ch,
    png_unf_out_if.source                      out_ch
);

    import png_unf_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);

    // configuration registers
    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic        has_alpha_reg;

    // stage 0: sequencing and line store read
    logic          accept;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    s1_ctrl_t      seq_ctrl;

    // stage 1: reconstruction and write back
    logic          s1_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    upper_byte;
    recon_res_t    res;
    logic          out_can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd1;
            image_height_reg <= 16'd1;
            has_alpha_reg    <= 1'b1;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= write_data[10:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= write_data[15:0];
                CFG_HAS_ALPHA:    has_alpha_reg    <= write_data[0];
                default:          ; // unused index, write ignored
            endcase
        end
    end

    // a byte is taken whenever stage 1 is empty or moving on
    assign in_ch.ready = s1_free;
    assign accept      = in_ch.valid && s1_free;

    // row and column counters, filter byte capture
    png_unf_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LINE_BYTES (LINE_BYTES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .raw_byte     (in_ch.raw_byte),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .has_alpha    (has_alpha_reg),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .ctrl         (seq_ctrl)
    );

    // previous row; a read of the byte written in the same cycle sees the new value
    png_unf_line_mem #(
        .DEPTH (LINE_BYTES)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (upper_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // filter arithmetic with the left and upper-left neighbours per channel
    png_unf_recon #(
        .LINE_BYTES (LINE_BYTES)
    ) u_recon (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .ctrl_in      (seq_ctrl),
        .raw_in       (in_ch.raw_byte),
        .addr_in      (rd_addr),
        .upper_byte   (upper_byte),
        .out_can_take (out_can_take),
        .free         (s1_free),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .res          (res)
    );

    // output register plus one slot for the inserted alpha byte
    png_unf_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .can_take (out_can_take),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

// ===== design/png_unf_checker.sv =====
`default_nettype none

module png_unf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pixel_byte,
    input logic [1:0] channel,
    input logic       last_of_row,
    input logic       last_of_image,
    input logic       last_in_run
);

    import png_unf_pkg::*;

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_byte) && $stable(channel)
            && $stable(last_of_row) && $stable(last_of_image) && $stable(last_in_run))
        else $error("output transaction changed while stalled");

    // an inserted alpha byte follows a blue byte at once
    a_alpha_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (channel == CH_BLUE) && !last_in_run
            |=> out_valid && (channel == CH_ALPHA) && (pixel_byte == ALPHA_OPAQUE)
                && last_in_run)
        else $error("blue byte not followed by opaque alpha");

    // only a blue byte before an inserted alpha leaves a run open
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_in_run |-> (channel == CH_BLUE) && !last_of_row && !last_of_image)
        else $error("open run on wrong byte");

    a_img_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_image |-> last_of_row)
        else $error("image end without row end");

endmodule

bind png_scanline_unfilter_rgba_core png_unf_checker u_png_unf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .pixel_byte    (out_ch.pixel_byte),
    .channel       (out_ch.channel),
    .last_of_row   (out_ch.last_of_row),
    .last_of_image (out_ch.last_of_image),
    .last_in_run   (out_ch.last_in_run)
);

`default_nettype wire
